// ===== sv/lyp_pkg.sv =====
// Shared types and constants for the look-at yaw/pitch pipeline.
// Used by every module of the block and by its checker; depends on nothing.
`timescale 1ns / 1ps
package lyp_pkg;

  // Coordinate difference width: two 32-bit operands never wrap at 33 bits.
  localparam int DW = 33;
  // CORDIC x/y datapath width; worst-case magnitude stays below 2^59.
  localparam int XW = 62;
  // Angle accumulator width in 2^-16 degree units (|z| < 2^24).
  localparam int ZW = 26;
  // Width of an angle after the Q8.8 rounding shift.
  localparam int RW = ZW - 7;

  localparam int PRESCALE    = 24;
  localparam int GAIN_W      = 26;
  localparam int TABLE_LEN   = 24;

  localparam logic signed [GAIN_W-1:0] GAIN_Q24     = 26'sd27628053;
  localparam logic signed [ZW-1:0]     QUARTER_TURN = 26'sd5898240;
  localparam logic signed [RW-1:0]     YAW_LIMIT    = 19'sd46080;
  localparam logic signed [RW-1:0]     PITCH_LIMIT  = 19'sd23040;

  // round(atan(2^-i) * 180/pi * 2^16)
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] own_z;
  } lyp_in_t;

  typedef struct packed {
    logic signed [16:0] yaw_deg;
    logic signed [15:0] pitch_deg;
    logic               degenerate;
  } lyp_out_t;

  // State of one item as it moves through the CORDIC stages.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [ZW-1:0] yaw_z;   // finished yaw angle, set between the two rotators
    logic signed [XW-1:0] dyg;     // vertical offset times gain, start of pitch y
    logic                 dy_zero;
    logic                 degen;
  } lyp_rot_t;

endpackage

// ===== sv/lyp_prep.sv =====
// Front end: coordinate differences, then prescale, quadrant fold and gain multiply.
// Two register stages with per-stage valid and ready. Depends on lyp_pkg.
`timescale 1ns / 1ps
module lyp_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  lyp_pkg::lyp_in_t   data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lyp_pkg::lyp_rot_t  data_o
);

  logic                            v1_q;
  logic                            rdy1;
  logic signed [lyp_pkg::DW-1:0]   dx_q, dy_q, dz_q;
  logic signed [lyp_pkg::DW-1:0]   dx_d, dy_d, dz_d;

  logic                            v2_q;
  logic                            rdy2;
  lyp_pkg::lyp_rot_t               s2_q, s2_d;

  logic signed [lyp_pkg::XW-1:0]   xp, yp;
  logic signed [lyp_pkg::DW+lyp_pkg::GAIN_W-1:0] prod;

  assign dx_d = lyp_pkg::DW'(data_i.target_x) - lyp_pkg::DW'(data_i.own_x);
  assign dy_d = lyp_pkg::DW'(data_i.target_y) - lyp_pkg::DW'(data_i.own_y);
  assign dz_d = lyp_pkg::DW'(data_i.target_z) - lyp_pkg::DW'(data_i.own_z);

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
    if (v1_q && rdy2) begin
      s2_q <= s2_d;
    end
  end

  assign xp   = lyp_pkg::XW'(dz_q) <<< lyp_pkg::PRESCALE;
  assign yp   = lyp_pkg::XW'(dx_q) <<< lyp_pkg::PRESCALE;
  assign prod = dy_q * lyp_pkg::GAIN_Q24;

  // Fold the left half-plane onto the right so vectoring starts with x >= 0.
  always_comb begin
    s2_d         = '0;
    s2_d.x       = xp;
    s2_d.y       = yp;
    s2_d.z       = '0;
    s2_d.yaw_z   = '0;
    s2_d.dyg     = lyp_pkg::XW'(prod);
    s2_d.dy_zero = (dy_q == '0);
    s2_d.degen   = (dx_q == '0) && (dz_q == '0);
    if (xp < 0) begin
      if (yp >= 0) begin
        s2_d.x = yp;
        s2_d.y = -xp;
        s2_d.z = lyp_pkg::QUARTER_TURN;
      end else begin
        s2_d.x = -yp;
        s2_d.y = xp;
        s2_d.z = -lyp_pkg::QUARTER_TURN;
      end
    end
  end

  assign valid_o = v2_q;
  assign data_o  = s2_q;

endmodule

// ===== sv/lyp_rot.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
// The shift amount is fixed per instance. Depends on lyp_pkg.
`timescale 1ns / 1ps
module lyp_rot #(
  parameter int SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  lyp_pkg::lyp_rot_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lyp_pkg::lyp_rot_t  data_o
);

  localparam logic signed [lyp_pkg::ZW-1:0] ANGLE = lyp_pkg::ATAN_TAB[SHIFT];

  logic                            valid_q;
  lyp_pkg::lyp_rot_t               data_q, data_d;
  logic signed [lyp_pkg::XW-1:0]   xs, ys;

  assign xs = data_i.x >>> SHIFT;
  assign ys = data_i.y >>> SHIFT;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    data_d = data_i;
    if (!data_i.y[lyp_pkg::XW-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + ANGLE;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - ANGLE;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/lyp_out.sv =====
// Back end: rounds both angles to Q8.8, clamps them, applies the special cases.
// Holds the output register. Depends on lyp_pkg.
`timescale 1ns / 1ps
module lyp_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  lyp_pkg::lyp_rot_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lyp_pkg::lyp_out_t  data_o
);

  logic                            valid_q;
  lyp_pkg::lyp_out_t               data_q, data_d;
  logic signed [lyp_pkg::ZW:0]     yaw_sum, pit_sum;
  logic signed [lyp_pkg::RW-1:0]   yaw_r, pit_r, yaw_c, pit_c, pit_n;

  assign yaw_sum = lyp_pkg::ZW'(data_i.yaw_z) + (lyp_pkg::ZW+1)'(128);
  assign pit_sum = lyp_pkg::ZW'(data_i.z) + (lyp_pkg::ZW+1)'(128);
  assign yaw_r   = lyp_pkg::RW'(yaw_sum >>> 8);
  assign pit_r   = lyp_pkg::RW'(pit_sum >>> 8);

  always_comb begin
    yaw_c = yaw_r;
    if (yaw_r > lyp_pkg::YAW_LIMIT)  yaw_c = lyp_pkg::YAW_LIMIT;
    if (yaw_r < -lyp_pkg::YAW_LIMIT) yaw_c = -lyp_pkg::YAW_LIMIT;
    pit_c = pit_r;
    if (pit_r > lyp_pkg::PITCH_LIMIT)  pit_c = lyp_pkg::PITCH_LIMIT;
    if (pit_r < -lyp_pkg::PITCH_LIMIT) pit_c = -lyp_pkg::PITCH_LIMIT;
  end

  assign pit_n = -pit_c;

  always_comb begin
    data_d.yaw_deg    = 17'(yaw_c);
    data_d.pitch_deg  = data_i.dy_zero ? '0 : 16'(pit_n);
    data_d.degenerate = 1'b0;
    if (data_i.degen) begin
      data_d.yaw_deg    = '0;
      data_d.pitch_deg  = '0;
      data_d.degenerate = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/look_at_yaw_pitch.sv =====
// An accepted transaction passes the prep registers, the yaw and pitch rotator
// stages and the out register in order. Throughput: one transaction per cycle
// while the output side does not stall; every micro-rotation has its own stage.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data registers
// are not reset. No other state is kept between transactions.
`timescale 1ns / 1ps
module look_at_yaw_pitch #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lyp_pkg::lyp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lyp_pkg::lyp_out_t  out_data_o
);

  // The pipeline is a chain of elastic stages. Each stage holds one transaction
  // with its own valid bit and takes a new one whenever it is empty or its
  // successor is taking the current one, so bubbles close up under a stall and
  // the input keeps flowing while a finished result waits at the output.
  //
  // Order of stages:
  //   prep   : differences dx, dy, dz (33 bits, never wrap), then prescale by
  //            2^24, fold dz < 0 onto the right half-plane with a +/-90 degree
  //            preset, and form dy times the CORDIC gain.
  //   yaw    : CORDIC_STEPS vectoring stages on (dz, dx) giving atan2(dx, dz)
  //            and the gain-scaled horizontal length.
  //   pitch  : CORDIC_STEPS vectoring stages on (length, dy * gain) giving
  //            atan2(dy, horizontal length).
  //   out    : Q8.8 rounding, clamping, pitch negation and the special cases
  //            (zero horizontal offset, zero vertical offset).

  logic [CORDIC_STEPS:0]  yaw_valid, yaw_ready;
  logic [CORDIC_STEPS:0]  pit_valid, pit_ready;
  lyp_pkg::lyp_rot_t      yaw_data [CORDIC_STEPS+1];
  lyp_pkg::lyp_rot_t      pit_data [CORDIC_STEPS+1];

  lyp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (yaw_valid[0]),
    .ready_i (yaw_ready[0]),
    .data_o  (yaw_data[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_yaw
    lyp_rot #(.SHIFT(i)) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (yaw_valid[i]),
      .ready_o (yaw_ready[i]),
      .data_i  (yaw_data[i]),
      .valid_o (yaw_valid[i+1]),
      .ready_i (yaw_ready[i+1]),
      .data_o  (yaw_data[i+1])
    );
  end

  // Hand-over between the two rotators: the yaw angle is parked in yaw_z, the
  // final x (gain times the horizontal length) becomes the pitch x, and the
  // vertical offset times the gain becomes the pitch y. No register here.
  always_comb begin
    pit_data[0]       = yaw_data[CORDIC_STEPS];
    pit_data[0].yaw_z = yaw_data[CORDIC_STEPS].z;
    pit_data[0].y     = yaw_data[CORDIC_STEPS].dyg;
    pit_data[0].z     = '0;
  end
  assign pit_valid[0]            = yaw_valid[CORDIC_STEPS];
  assign yaw_ready[CORDIC_STEPS] = pit_ready[0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pitch
    lyp_rot #(.SHIFT(i)) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pit_valid[i]),
      .ready_o (pit_ready[i]),
      .data_i  (pit_data[i]),
      .valid_o (pit_valid[i+1]),
      .ready_i (pit_ready[i+1]),
      .data_o  (pit_data[i+1])
    );
  end

  lyp_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pit_valid[CORDIC_STEPS]),
    .ready_o (pit_ready[CORDIC_STEPS]),
    .data_i  (pit_data[CORDIC_STEPS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== sv/lyp_checker.sv =====
// Port-level checks for look_at_yaw_pitch and the bind that attaches them.
// Depends on lyp_pkg and the top-level port list.
`timescale 1ns / 1ps
module lyp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input lyp_pkg::lyp_in_t   in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lyp_pkg::lyp_out_t  out_data_o
);

  // An offered input transaction stays put until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while waiting");

  // A result that is waiting must not change or vanish.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // A degenerate result carries zero angles.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.yaw_deg == '0 && out_data_o.pitch_deg == '0)
    else $error("degenerate result with nonzero angle");

  // Angles stay within their clamped ranges.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(out_data_o.yaw_deg) <= 17'sd46080 &&
      $signed(out_data_o.yaw_deg) >= -17'sd46080 &&
      $signed(out_data_o.pitch_deg) <= 16'sd23040 &&
      $signed(out_data_o.pitch_deg) >= -16'sd23040)
    else $error("angle out of range");

  // Nothing can reach the output right after reset; the pipeline is empty.
  a_empty_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind look_at_yaw_pitch lyp_checker u_lyp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== sim/look_at_yaw_pitch_test.sv =====
// Self-checking testbench for the look_at_yaw_pitch CORDIC yaw/pitch pipeline.
// Depends on lyp_pkg for the transaction types and on the look_at_yaw_pitch RTL.
`timescale 1ns / 1ps
module look_at_yaw_pitch_test;

  // The block is built with its default number of micro-rotations. The
  // predictor below uses the same count.
  localparam int STEPS = 16;
  // Latency from an accepted transaction to its result, plus some slack for
  // the final drain.
  localparam int DRAIN = 2 * STEPS + 3 + 20;
  // Watchdog limit; it exceeds what a run needs in which every transaction is hit
  // by the longest sender gap and the longest receiver stall.
  localparam int CYCLE_LIMIT = 400000;

  localparam longint PRESCALE_MUL = 64'sd1 <<< 24;
  localparam longint GAIN_Q24_L = 64'sd27628053;
  localparam longint QUARTER_Q16 = 64'sd5898240;
  localparam longint YAW_MAX = 64'sd46080;
  localparam longint PITCH_MAX = 64'sd23040;

  localparam logic signed [31:0] MAXC = 32'sh7fffffff;
  localparam logic signed [31:0] MINC = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sd65536;

  // Micro-rotation angles in units of 2^-16 degree.
  localparam longint ATAN_Q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  lyp_pkg::lyp_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  lyp_pkg::lyp_out_t out_data;

  // Angles predicted for accepted transactions, oldest first.
  lyp_pkg::lyp_out_t angle_q[$];

  int  errors;
  int  sent_count;
  int  checked_count;
  int  degen_count;
  int  cycle_count;
  bit  gaps_on;
  bit  stalls_on;

  look_at_yaw_pitch #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Angle predictor.
  // ---------------------------------------------------------------------------

  // CORDIC vectoring with x >= 0. Returns atan2(y, x) in 2^-16 degree and
  // gives back the final x, which carries the CORDIC gain. The shifts of a
  // signed longint are arithmetic, so they round toward minus infinity.
  function automatic longint vector_angle(input longint xi, input longint yi,
                                          output longint xo);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint z;
    x = xi;
    y = yi;
    z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    xo = x;
    return z;
  endfunction

  // Rounds an angle from 2^-16 degree to Q8.8 and clamps it symmetrically.
  function automatic longint round_to_q8_8(input longint z, input longint lim);
    longint r;
    r = (z + 128) >>> 8;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic lyp_pkg::lyp_out_t predict_angles(input lyp_pkg::lyp_in_t p);
    longint            dx;
    longint            dy;
    longint            dz;
    longint            x;
    longint            y;
    longint            t;
    longint            z0;
    longint            hx;
    longint            zp;
    longint            unused_x;
    longint            yaw;
    longint            pitch;
    lyp_pkg::lyp_out_t r;
    r = '0;
    // The differences are formed at 64 bits, so no pair of coordinates wraps.
    dx = longint'(p.target_x) - longint'(p.own_x);
    dy = longint'(p.target_y) - longint'(p.own_y);
    dz = longint'(p.target_z) - longint'(p.own_z);
    if (dx == 0 && dz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    x = dz * PRESCALE_MUL;
    y = dx * PRESCALE_MUL;
    z0 = 0;
    // A vector in the back half plane is first turned by a quarter turn so
    // that vectoring starts with x >= 0. Straight behind goes toward +180.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z0 = QUARTER_Q16;
      end else begin
        x = -y;
        y = t;
        z0 = -QUARTER_Q16;
      end
    end
    yaw = round_to_q8_8(z0 + vector_angle(x, y, hx), YAW_MAX);
    pitch = 0;
    if (dy != 0) begin
      zp = vector_angle(hx, dy * GAIN_Q24_L, unused_x);
      pitch = -round_to_q8_8(zp, PITCH_MAX);
    end
    r.yaw_deg = yaw[16:0];
    r.pitch_deg = pitch[15:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge, before any of the
  // nonblocking updates of that edge take effect, which matches what the DUT
  // registers see.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lyp_pkg::lyp_out_t exp_angles;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        angle_q.insert(angle_q.size(), predict_angles(in_data));
      end
      if (out_valid && out_ready) begin
        if (angle_q.size() == 0) begin
          $error("unexpected result: yaw_deg %0d, pitch_deg %0d, degenerate %0d",
                 out_data.yaw_deg, out_data.pitch_deg, out_data.degenerate);
          errors++;
        end else begin
          exp_angles = angle_q.pop_front();
          checked_count++;
          if (exp_angles.degenerate) degen_count++;
          if (out_data.yaw_deg !== exp_angles.yaw_deg) begin
            $error("yaw_deg: expected %0d, actual %0d",
                   exp_angles.yaw_deg, out_data.yaw_deg);
            errors++;
          end
          if (out_data.pitch_deg !== exp_angles.pitch_deg) begin
            $error("pitch_deg: expected %0d, actual %0d",
                   exp_angles.pitch_deg, out_data.pitch_deg);
            errors++;
          end
          if (out_data.degenerate !== exp_angles.degenerate) begin
            $error("degenerate: expected %0d, actual %0d",
                   exp_angles.degenerate, out_data.degenerate);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, angle_q.size());
      $display("** look_at_yaw_pitch: FAILED **");
      $finish;
    end
  end

  // Result side: ready drops in bursts while stalls are enabled, with runs of
  // ready in between. Exactly one assignment is made at any edge, so the value
  // never glitches within a time step.
  initial begin
    @(posedge rst_n);
    forever begin
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  function automatic lyp_pkg::lyp_in_t make_point(input logic signed [31:0] tx,
                                                  input logic signed [31:0] ty,
                                                  input logic signed [31:0] tz,
                                                  input logic signed [31:0] ox,
                                                  input logic signed [31:0] oy,
                                                  input logic signed [31:0] oz);
    lyp_pkg::lyp_in_t p;
    p.target_x = tx;
    p.target_y = ty;
    p.target_z = tz;
    p.own_x = ox;
    p.own_y = oy;
    p.own_z = oz;
    return p;
  endfunction

  // Mostly uniform 32-bit values, with the extremes mixed in.
  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(0, 9))
      0: return MAXC;
      1: return MINC;
      2: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // A signed offset whose magnitude ranges from zero to a large value.
  function automatic logic signed [31:0] near_offset();
    int unsigned span;
    case ($urandom_range(0, 4))
      0: span = 1;
      1: span = 255;
      2: span = 65535;
      3: span = 32'h00ffffff;
      default: span = 32'h3fffffff;
    endcase
    if ($urandom_range(0, 5) == 0) return 32'sd0;
    return $signed($urandom_range(0, span)) * ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  // Presents one transaction and holds it until it is taken. Valid stays high
  // across back-to-back transactions; a gap, when one is drawn, comes first.
  task automatic send_point(input lyp_pkg::lyp_in_t p);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Zero horizontal offset, the axis directions, straight behind, zero
  // vertical offset, steep pitch and differences that need all 33 bits.
  task automatic test_directed();
    send_point(make_point(0, 0, 0, 0, 0, 0));
    send_point(make_point(5, ONE, 7, 5, 0, 7));
    send_point(make_point(3, MAXC, -9, 3, MINC, -9));
    send_point(make_point(MINC, MINC, MAXC, MINC, MAXC, MAXC));
    send_point(make_point(0, 0, ONE, 0, 0, 0));
    send_point(make_point(0, 0, -ONE, 0, 0, 0));
    send_point(make_point(0, 0, MINC, 0, 0, MAXC));
    send_point(make_point(0, ONE, -1, 0, 0, 0));
    send_point(make_point(ONE, 0, 0, 0, 0, 0));
    send_point(make_point(-ONE, 0, 0, 0, 0, 0));
    send_point(make_point(ONE, 0, ONE, 0, 0, 0));
    send_point(make_point(-ONE, 0, -ONE, 0, 0, 0));
    send_point(make_point(ONE, -ONE, -ONE, 0, 0, 0));
    send_point(make_point(1, 0, -1, 0, 0, 0));
    send_point(make_point(1, MAXC, 0, 0, MINC, 0));
    send_point(make_point(0, MINC, 1, 0, MAXC, 0));
    send_point(make_point(MAXC, MAXC, MAXC, MINC, MINC, MINC));
    send_point(make_point(MINC, MINC, MINC, MAXC, MAXC, MAXC));
    send_point(make_point(MAXC, MINC, MINC, MINC, MAXC, MAXC));
    send_point(make_point(MINC, 0, MAXC, MAXC, 0, MINC));
    send_point(make_point(-1, -1, -1, 0, 0, 0));
    send_point(make_point(1, 1, 1, 0, 0, 0));
  endtask

  // Unrelated target and viewer points anywhere in the coordinate range.
  task automatic test_random_wide(input int count);
    repeat (count) begin
      send_point(make_point(any_coord(), any_coord(), any_coord(),
                            any_coord(), any_coord(), any_coord()));
    end
  endtask

  // A target close to the viewer, offset per axis by anything from zero to a
  // large value. Zero offsets give the degenerate and level cases often.
  task automatic test_random_near(input int count);
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    repeat (count) begin
      ox = any_coord();
      oy = any_coord();
      oz = any_coord();
      send_point(make_point(ox + near_offset(), oy + near_offset(), oz + near_offset(),
                            ox, oy, oz));
    end
  endtask

  // Full rate on both sides: a new transaction every cycle and no output stall.
  task automatic test_full_rate(input int count);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (count) begin
      if ($urandom_range(0, 1)) begin
        send_point(make_point(any_coord(), any_coord(), any_coord(),
                              any_coord(), any_coord(), any_coord()));
      end else begin
        send_point(make_point(near_offset(), near_offset(), near_offset(), 0, 0, 0));
      end
    end
  endtask

  initial begin
    errors = 0;
    sent_count = 0;
    checked_count = 0;
    degen_count = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_wide(700);
    test_random_near(700);
    test_full_rate(330);
    in_valid <= 1'b0;

    while (angle_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d point pairs (directed, wide random, near random, full rate);",
             sent_count);
    $display("checked %0d angle results, %0d of them degenerate.",
             checked_count, degen_count);
    if (errors == 0) begin
      $display("** look_at_yaw_pitch: PASSED **");
    end else begin
      $display("** look_at_yaw_pitch: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lyp_pkg.sv
sv/lyp_prep.sv
sv/lyp_rot.sv
sv/lyp_out.sv
sv/look_at_yaw_pitch.sv
sv/lyp_checker.sv
sim/look_at_yaw_pitch_test.sv
